>>> sv/bptc_pkg.sv
// shared types, register codes and arithmetic helpers for the compensation block
package bptc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PRESS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PRESS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PRESS_C = 2'd3;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } sample_t;

    typedef struct packed {
        logic [23:0]        pressure_centi;
        logic signed [15:0] temperature_centi;
    } result_t;

    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } cal_t;

    // word handed from the temperature half to the pressure half
    typedef struct packed {
        logic               valid;
        logic signed [27:0] tfine;
        logic [23:0]        rp;
        logic signed [40:0] bq;
    } tword_t;

    // signed divide by 2^k, truncating toward zero
    function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                     input int unsigned k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        logic signed [15:0] r;
        if (x > 64'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (x < -64'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

>>> sv/baro_temp_pressure_compensation_unit.sv
// top level of the barometer temperature and pressure compensation block
//
//  channel   | handshake                     | word
//  ----------+-------------------------------+-------------------------------
//  sample    | sample_valid / sample_stall   | raw_temperature, raw_pressure
//  result    | result_valid / result_stall   | temperature_centi, pressure_centi
//  config    | cfg_we (no wait)              | cfg_idx, cfg_data
//
// one word enters per cycle while the pipe is not stalled; each word leaves
// after the chain of multiplies from fine temperature to pressure.
// every stage advances together; a stalled result freezes the whole pipe,
// so nothing is dropped or repeated.
// reset clears the calibration registers and all stage valid bits.
module baro_temp_pressure_compensation_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  bptc_pkg::sample_t               sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output bptc_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [bptc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bptc_pkg::*;

    cal_t   cal;
    tword_t tword;
    logic   en;

    // pipe moves unless a finished word is held at the output
    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;

    bptc_cal_regs u_cal (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cal      (cal)
    );

    // stages 1-4: fine temperature
    bptc_temp_pipe u_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sample_valid),
        .in_word  (sample),
        .cal      (cal),
        .tword    (tword)
    );

    // stages 5-12: offset, sensitivity, pressure and output register
    bptc_press_pipe u_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tword     (tword),
        .cal       (cal),
        .out_valid (result_valid),
        .out_word  (result)
    );

endmodule

>>> sv/bptc_cal_regs.sv
// calibration register file and field unpacking
module bptc_cal_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [bptc_pkg::CFG_DATA_W-1:0] cfg_data,
    output bptc_pkg::cal_t                 cal
);
    import bptc_pkg::*;

    logic [39:0] cal_temp_reg;
    logic [47:0] cal_press_a_reg;
    logic [47:0] cal_press_b_reg;
    logic [31:0] cal_press_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_press_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_CAL_TEMP:    cal_temp_reg    <= cfg_data[39:0];
                REG_CAL_PRESS_A: cal_press_a_reg <= cfg_data;
                REG_CAL_PRESS_B: cal_press_b_reg <= cfg_data;
                REG_CAL_PRESS_C: cal_press_c_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign cal.t1  = cal_temp_reg[15:0];
    assign cal.t2  = cal_temp_reg[31:16];
    assign cal.t3  = cal_temp_reg[39:32];
    assign cal.p1  = cal_press_a_reg[15:0];
    assign cal.p2  = cal_press_a_reg[31:16];
    assign cal.p3  = cal_press_a_reg[39:32];
    assign cal.p4  = cal_press_a_reg[47:40];
    assign cal.p5  = cal_press_b_reg[15:0];
    assign cal.p6  = cal_press_b_reg[31:16];
    assign cal.p7  = cal_press_b_reg[39:32];
    assign cal.p8  = cal_press_b_reg[47:40];
    assign cal.p9  = cal_press_c_reg[15:0];
    assign cal.p10 = cal_press_c_reg[23:16];
    assign cal.p11 = cal_press_c_reg[31:24];

endmodule

>>> sv/bptc_temp_pipe.sv
// four-stage pipeline from raw readings to fine temperature
module bptc_temp_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  bptc_pkg::sample_t in_word,
    input  bptc_pkg::cal_t    cal,
    output bptc_pkg::tword_t  tword
);
    import bptc_pkg::*;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [25:0] a_reg;
    logic [23:0]        rp1_reg, rp2_reg, rp3_reg, rp4_reg;
    logic signed [42:0] b_reg;
    logic signed [51:0] c_reg;
    logic [47:0]        ff_reg;
    logic signed [63:0] e_reg;
    logic signed [56:0] q_reg;
    logic signed [27:0] tf_reg;
    logic signed [40:0] bq_reg;

    logic signed [25:0] a_next;
    logic signed [42:0] b_next;
    logic signed [51:0] c_next;
    logic [47:0]        ff_next;
    logic signed [59:0] ct3;
    logic signed [63:0] e_next;
    logic signed [56:0] q_next;
    logic signed [63:0] tf_full;
    logic signed [63:0] bq_full;

    assign a_next  = $signed({2'b00, in_word.raw_temperature})
                   - $signed({2'b00, cal.t1, 8'h00});
    assign b_next  = $signed({1'b0, cal.t2}) * a_reg;
    assign c_next  = a_reg * a_reg;
    assign ff_next = rp1_reg * rp1_reg;
    assign ct3     = c_reg * cal.t3;
    assign e_next  = (64'(b_reg) <<< 18) + 64'(ct3);
    assign q_next  = cal.p11 * $signed({1'b0, ff_reg});
    assign tf_full = sdiv_pow2(e_reg, 32);
    assign bq_full = sdiv_pow2(64'(q_reg), 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_next;
            rp1_reg <= in_word.raw_pressure;
            b_reg   <= b_next;
            c_reg   <= c_next;
            ff_reg  <= ff_next;
            rp2_reg <= rp1_reg;
            e_reg   <= e_next;
            q_reg   <= q_next;
            rp3_reg <= rp2_reg;
            tf_reg  <= tf_full[27:0];
            bq_reg  <= bq_full[40:0];
            rp4_reg <= rp3_reg;
        end
    end

    assign tword.valid = v4_reg;
    assign tword.tfine = tf_reg;
    assign tword.rp    = rp4_reg;
    assign tword.bq    = bq_reg;

endmodule

>>> sv/bptc_press_pipe.sv
// eight-stage pipeline from fine temperature to compensated outputs
module bptc_press_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  bptc_pkg::tword_t  tword,
    input  bptc_pkg::cal_t    cal,
    output logic              out_valid,
    output bptc_pkg::result_t out_word
);
    import bptc_pkg::*;

    logic [7:0] v_reg;

    // stage 5
    logic signed [55:0] a2_reg;
    logic signed [32:0] ct25_reg;
    logic signed [44:0] f0_reg;
    logic signed [45:0] e0_reg;
    logic signed [35:0] b10_reg;
    logic signed [63:0] bqr_reg;
    logic signed [27:0] tf5_reg;
    logic [23:0]        rp5_reg;
    // stage 6
    logic signed [52:0] pl_reg, ph_reg;
    logic signed [15:0] t6_reg, t7_reg, t8_reg, t9_reg, t10_reg, t11_reg, t12_reg;
    logic signed [63:0] e7_reg, d3_reg, cq6_reg;
    logic signed [36:0] c9_reg;
    logic signed [44:0] f06_reg;
    logic signed [45:0] e06_reg;
    logic [23:0]        rp6_reg;
    // stage 7
    logic signed [63:0] c3_reg, cr_reg;
    logic signed [63:0] e77_reg, d37_reg, cq7_reg;
    logic signed [44:0] f07_reg;
    logic signed [45:0] e07_reg;
    logic [23:0]        rp7_reg;
    // stage 8
    logic signed [63:0] d8_reg, b4_reg, dr_reg;
    logic signed [63:0] e78_reg, d38_reg, cq8_reg;
    logic signed [44:0] f08_reg;
    logic signed [45:0] e08_reg;
    logic [23:0]        rp8_reg;
    // stage 9
    logic signed [63:0] off_reg, sens_reg, cq9_reg;
    logic signed [49:0] drl_reg;
    logic signed [50:0] drh_reg;
    logic [23:0]        rp9_reg;
    // stage 10
    logic signed [63:0] off4_reg, sa_reg, er_reg, cq10_reg;
    // stage 11
    logic signed [63:0] dsum_reg;
    // stage 12
    logic [23:0]        press_reg;

    logic signed [17:0] p1m, p2m;
    logic signed [63:0] b2, ct, prod, cr_next;
    logic signed [52:0] pl_next, ph_next;
    logic signed [55:0] c3n;
    logic signed [63:0] off_next, sens_next, sa_next, er_next, d25;
    logic signed [39:0] sdv;

    assign p1m = 18'(cal.p1) - 18'sd16384;
    assign p2m = 18'(cal.p2) - 18'sd16384;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[6:0], tword.valid};
        end
    end

    assign b2      = sdiv_pow2(64'(a2_reg), 6);
    assign ct      = sdiv_pow2(64'(ct25_reg), 14);
    assign pl_next = $signed({1'b0, b2[23:0]}) * tf5_reg;
    assign ph_next = $signed(b2[48:24]) * tf5_reg;
    assign prod    = 64'(pl_reg) + (64'(ph_reg) <<< 24);
    assign cr_next = c9_reg * $signed({1'b0, rp6_reg});
    assign c3n     = c3_reg[55:0];
    assign off_next = ({48'd0, cal.p5} << 47) + d8_reg + (e78_reg <<< 4)
                    + (64'(f08_reg) <<< 22);
    assign sens_next = (64'(p1m) <<< 46) + b4_reg + (d38_reg <<< 2)
                     + (64'(e08_reg) <<< 21);
    assign sdv     = 40'(sdiv_pow2(sens_reg, 24));
    assign sa_next = sdv * $signed({1'b0, rp9_reg});
    assign er_next = sdiv_pow2(64'(drl_reg) + (64'(drh_reg) <<< 24), 9);
    assign d25     = (dsum_reg <<< 4) + (dsum_reg <<< 3) + dsum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg   <= tword.tfine * tword.tfine;
            ct25_reg <= tword.tfine * 33'sd25;
            f0_reg   <= $signed({1'b0, cal.p6}) * tword.tfine;
            e0_reg   <= p2m * tword.tfine;
            b10_reg  <= cal.p10 * tword.tfine;
            bqr_reg  <= tword.bq * $signed({1'b0, tword.rp});
            tf5_reg  <= tword.tfine;
            rp5_reg  <= tword.rp;

            pl_reg  <= pl_next;
            ph_reg  <= ph_next;
            t6_reg  <= sat16(ct);
            e7_reg  <= a2_reg * cal.p7;
            d3_reg  <= a2_reg * cal.p3;
            // p10 * tfine plus p9 * 2^16 stays well inside 37 bits
            c9_reg  <= 37'(b10_reg) + (37'(cal.p9) <<< 16);
            cq6_reg <= sdiv_pow2(bqr_reg, 7);
            f06_reg <= f0_reg;
            e06_reg <= e0_reg;
            rp6_reg <= rp5_reg;

            c3_reg  <= sdiv_pow2(prod, 8);
            cr_reg  <= cr_next;
            t7_reg  <= t6_reg;
            e77_reg <= e7_reg;
            d37_reg <= d3_reg;
            cq7_reg <= cq6_reg;
            f07_reg <= f06_reg;
            e07_reg <= e06_reg;
            rp7_reg <= rp6_reg;

            d8_reg  <= sdiv_pow2(64'(c3n * cal.p8), 5);
            b4_reg  <= sdiv_pow2(64'(c3n * cal.p4), 5);
            dr_reg  <= sdiv_pow2(cr_reg, 13);
            t8_reg  <= t7_reg;
            e78_reg <= e77_reg;
            d38_reg <= d37_reg;
            cq8_reg <= cq7_reg;
            f08_reg <= f07_reg;
            e08_reg <= e07_reg;
            rp8_reg <= rp7_reg;

            off_reg  <= off_next;
            sens_reg <= sens_next;
            drl_reg  <= $signed({1'b0, dr_reg[23:0]}) * $signed({1'b0, rp8_reg});
            drh_reg  <= $signed(dr_reg[49:24]) * $signed({1'b0, rp8_reg});
            cq9_reg  <= cq8_reg;
            t9_reg   <= t8_reg;
            rp9_reg  <= rp8_reg;

            off4_reg <= sdiv_pow2(off_reg, 2);
            sa_reg   <= sa_next;
            er_reg   <= er_next;
            cq10_reg <= cq9_reg;
            t10_reg  <= t9_reg;

            dsum_reg <= off4_reg + sa_reg + er_reg + cq10_reg;
            t11_reg  <= t10_reg;

            // top 24 bits of the signed 64-bit word d25 are taken as is, with no saturation
            press_reg <= d25[63:40];
            t12_reg   <= t11_reg;
        end
    end

    assign out_valid                  = v_reg[7];
    assign out_word.pressure_centi    = press_reg;
    assign out_word.temperature_centi = t12_reg;

endmodule
